// ===== hdl/swj_pkg.sv =====
package swj_pkg;

    // Fraction bits of the coordinate and width registers
    localparam int COORD_FRAC_BITS = 12;
    localparam int COORD_W         = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_EDGE = 2'd2;

    // Q1.16 unity and half
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // Register stages: nine per axis, two for the tensor product
    localparam int PIPE_DEPTH = 11;

    typedef struct packed {
        logic [22:0] half_width;
        logic [22:0] edge_width;
        logic [23:0] recip_edge;
        logic [27:0] a15;      // 15*a
        logic [35:0] a2q15;    // 15*round(a^2 / 2^16)
    } cfg_t;

    typedef struct packed {
        logic [16:0] v;        // value, Q1.16
        logic [23:0] s_mag;    // slope magnitude
        logic        s_neg;
        logic [32:0] c_mag;    // half-curvature magnitude
        logic        c_neg;
    } axis_jet_t;

    typedef struct packed {
        logic [16:0] val_00;
        logic [31:0] dx_10;
        logic [31:0] dy_01;
        logic [31:0] dxx_20;
        logic [31:0] dxy_11;
        logic [31:0] dyy_02;
        logic        inside_res;
    } res_t;

endpackage

// ===== hdl/swj_in_if.sv =====
interface swj_in_if import swj_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ===== hdl/swj_out_if.sv =====
interface swj_out_if import swj_pkg::*; ();
    logic               valid;
    logic               ready;
    logic        [16:0] val_00;
    logic signed [31:0] dx_10;
    logic signed [31:0] dy_01;
    logic signed [31:0] dxx_20;
    logic signed [31:0] dxy_11;
    logic signed [31:0] dyy_02;
    logic               inside_res;

    modport source (
        output valid, output val_00, output dx_10, output dy_01, output dxx_20,
        output dxy_11, output dyy_02, output inside_res, input ready
    );
    modport sink (
        input valid, input val_00, input dx_10, input dy_01, input dxx_20,
        input dxy_11, input dyy_02, input inside_res, output ready
    );
endinterface

// ===== hdl/smooth_window_jet_2d.sv =====
// Channel   Role     Transfer when            Payload
// coord     sink     valid && ready           x_coord, y_coord (Q12.12 signed)
// jet       source   valid && ready           val_00, five Q16.16 jet terms, inside_res
// cfg       write    cfg_we                   cfg_idx selects register, cfg_wdata
//
// One coordinate pair enters per clock while the output is not stalled; each result
// passes the nine-stage axis pipeline (multiply stages alternate with rounding
// stages) plus two stages for the tensor product.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes every stage at once; the pipeline keeps
// taking items while its last stage is empty.
module smooth_window_jet_2d import swj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    swj_in_if.sink                coord,
    swj_out_if.source             jet
);

    cfg_t                  cfg;
    axis_jet_t             jet_x, jet_y;
    res_t                  res;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  adv;

    // Advance the whole pipeline whenever the output stage is free or drains
    assign adv         = !valid_reg[PIPE_DEPTH-1] || jet.ready;
    assign coord.ready = adv;
    assign valid_next  = {valid_reg[PIPE_DEPTH-2:0], coord.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Register file and derived reciprocal factors
    swj_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // One jet pipeline per axis
    swj_axis u_axis_x (
        .clk (clk),
        .adv (adv),
        .cfg (cfg),
        .p   (coord.x_coord),
        .jet (jet_x)
    );

    swj_axis u_axis_y (
        .clk (clk),
        .adv (adv),
        .cfg (cfg),
        .p   (coord.y_coord),
        .jet (jet_y)
    );

    // Tensor product, rounding and saturation; its last stage is the output register
    swj_tensor u_tensor (
        .clk (clk),
        .adv (adv),
        .jx  (jet_x),
        .jy  (jet_y),
        .res (res)
    );

    assign jet.valid      = valid_reg[PIPE_DEPTH-1];
    assign jet.val_00     = res.val_00;
    assign jet.dx_10      = res.dx_10;
    assign jet.dy_01      = res.dy_01;
    assign jet.dxx_20     = res.dxx_20;
    assign jet.dxy_11     = res.dxy_11;
    assign jet.dyy_02     = res.dyy_02;
    assign jet.inside_res = res.inside_res;

endmodule

// ===== hdl/swj_cfg.sv =====
module swj_cfg import swj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [22:0] half_width_reg;
    logic [22:0] edge_width_reg;
    logic [23:0] recip_edge_reg;
    logic [32:0] a2q_reg;
    logic [27:0] a15_reg;
    logic [35:0] a2q15_reg;
    logic [47:0] a_sq;
    logic [48:0] a_sq_rnd;
    logic [32:0] a2q_next;

    always_comb
    begin
        a_sq     = 48'(cfg_wdata) * 48'(cfg_wdata);
        a_sq_rnd = 49'(a_sq) + 49'(HALF_Q16);
        a2q_next = a_sq_rnd[48:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= 23'd4096;
            edge_width_reg <= 23'd1024;
            recip_edge_reg <= 24'd262144;
            a2q_reg        <= 33'd1048576;
            a15_reg        <= 28'd3932160;
            a2q15_reg      <= 36'd15728640;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_HALF_WIDTH: half_width_reg <= cfg_wdata[22:0];
                    CFG_EDGE_WIDTH: edge_width_reg <= cfg_wdata[22:0];
                    CFG_RECIP_EDGE:
                    begin
                        recip_edge_reg <= cfg_wdata;
                        a2q_reg        <= a2q_next;
                    end
                    default: ;
                endcase
            end
            // Derived scale factors follow the written register in the cycle after it
            a15_reg   <= (28'(recip_edge_reg) << 4) - 28'(recip_edge_reg);
            a2q15_reg <= (36'(a2q_reg) << 4) - 36'(a2q_reg);
        end
    end

    assign cfg.half_width = half_width_reg;
    assign cfg.edge_width = edge_width_reg;
    assign cfg.recip_edge = recip_edge_reg;
    assign cfg.a15        = a15_reg;
    assign cfg.a2q15      = a2q15_reg;

endmodule

// ===== hdl/swj_axis.sv =====
module swj_axis import swj_pkg::*;
(
    input  logic                      clk,
    input  logic                      adv,
    input  cfg_t                      cfg,
    input  logic signed [COORD_W-1:0] p,
    output axis_jet_t                 jet
);

    typedef struct packed {
        logic band;
        logic plat;
        logic left;
        logic neg;
    } seg_t;

    localparam logic [48:0] T_RND   = 49'(1) << (COORD_FRAC_BITS - 1);
    localparam logic [20:0] Q_BASE  = 21'd983040;

    // Stage A: region decode and distance to the band center
    logic signed [25:0] p_ext, h_ext, e_ext, d_val;
    logic [25:0] d_mag;
    logic        outside, left_b, plat_b;
    seg_t        a_seg_next;

    always_comb
    begin
        p_ext   = {{(26 - COORD_W){p[COORD_W-1]}}, p};
        h_ext   = {3'b000, cfg.half_width};
        e_ext   = {3'b000, cfg.edge_width};
        outside = (p_ext <= -h_ext - e_ext) || (p_ext >= h_ext + e_ext);
        left_b  = p_ext < e_ext - h_ext;
        plat_b  = p_ext < h_ext - e_ext;
        d_val   = left_b ? p_ext + h_ext : p_ext - h_ext;
        d_mag   = d_val[25] ? 26'(-d_val) : 26'(d_val);
        a_seg_next.band = !outside && (left_b || !plat_b);
        a_seg_next.plat = !outside && !left_b && plat_b;
        a_seg_next.left = left_b;
        a_seg_next.neg  = d_val[25];
    end

    seg_t        a_seg_reg, b_seg_reg, c_seg_reg, d_seg_reg;
    seg_t        e_seg_reg, f_seg_reg, g_seg_reg, h_seg_reg;
    logic [23:0] a_dm_reg;
    logic [47:0] b_prod_reg;
    logic [16:0] c_tm_reg, d_tm_reg, e_tm_reg, f_tm_reg, g_tm_reg;
    logic [33:0] d_tt_reg;
    logic [16:0] e_sq_reg, e_w_reg, f_sq_reg;
    logic [33:0] f_ss_reg, f_ww_reg, f_tw_reg;
    logic [19:0] g_q_reg;
    logic [16:0] g_twq_reg;
    logic [32:0] g_ww_reg;
    logic [36:0] h_mq_reg;
    logic [60:0] h_sw_reg;
    logic [52:0] h_cw_reg;
    axis_jet_t   jet_reg;

    // Stage C: round t and clamp to 1.0
    logic [48:0] t_sum;
    logic [16:0] c_tm_next;

    always_comb
    begin
        t_sum     = 49'(b_prod_reg) + T_RND;
        c_tm_next = ((t_sum >> COORD_FRAC_BITS) > 49'(ONE_Q16)) ?
                    ONE_Q16 : t_sum[COORD_FRAC_BITS +: 17];
    end

    // Stage E: s = round(t^2), w = 1 - s
    logic [33:0] tt_sum;
    logic [16:0] e_sq_next;

    always_comb
    begin
        tt_sum    = d_tt_reg + 34'(HALF_Q16);
        e_sq_next = tt_sum[32:16];
    end

    // Stage G: s^2, polynomial and t*w rounding
    logic [33:0] ss_sum, tw_sum;
    logic [16:0] sq2;
    logic [20:0] q_full;

    always_comb
    begin
        ss_sum = f_ss_reg + 34'(HALF_Q16);
        tw_sum = f_tw_reg + 34'(HALF_Q16);
        sq2    = ss_sum[32:16];
        q_full = Q_BASE + 21'd3 * 21'(sq2) - 21'd10 * 21'(f_sq_reg);
    end

    // Stage I: ramp value, slope and half-curvature
    logic [36:0] mq_sum;
    logic [16:0] m_full, m_cl, u_val, v_band;
    logic [61:0] sw_sum;
    logic [53:0] cw_sum;
    axis_jet_t   jet_next;

    always_comb
    begin
        mq_sum = h_mq_reg + 37'(1 << 19);
        m_full = mq_sum[36:20];
        m_cl   = (m_full > HALF_Q16) ? HALF_Q16 : m_full;
        u_val  = h_seg_reg.neg ? HALF_Q16 + m_cl : HALF_Q16 - m_cl;
        v_band = h_seg_reg.left ? ONE_Q16 - u_val : u_val;
        sw_sum = 62'(h_sw_reg) + (62'(1) << 35);
        cw_sum = 54'(h_cw_reg) + (54'(1) << 18);

        jet_next.v     = h_seg_reg.band ? v_band :
                         (h_seg_reg.plat ? ONE_Q16 : 17'd0);
        jet_next.s_mag = h_seg_reg.band ? sw_sum[59:36] : 24'd0;
        jet_next.s_neg = h_seg_reg.band && !h_seg_reg.left;
        jet_next.c_mag = h_seg_reg.band ? cw_sum[51:19] : 33'd0;
        jet_next.c_neg = h_seg_reg.band && (h_seg_reg.neg ^ h_seg_reg.left);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_seg_reg  <= a_seg_next;
            a_dm_reg   <= d_mag[23:0];

            b_seg_reg  <= a_seg_reg;
            b_prod_reg <= 48'(cfg.recip_edge) * 48'(a_dm_reg);

            c_seg_reg  <= b_seg_reg;
            c_tm_reg   <= c_tm_next;

            d_seg_reg  <= c_seg_reg;
            d_tm_reg   <= c_tm_reg;
            d_tt_reg   <= 34'(c_tm_reg) * 34'(c_tm_reg);

            e_seg_reg  <= d_seg_reg;
            e_tm_reg   <= d_tm_reg;
            e_sq_reg   <= e_sq_next;
            e_w_reg    <= ONE_Q16 - e_sq_next;

            f_seg_reg  <= e_seg_reg;
            f_tm_reg   <= e_tm_reg;
            f_sq_reg   <= e_sq_reg;
            f_ss_reg   <= 34'(e_sq_reg) * 34'(e_sq_reg);
            f_ww_reg   <= 34'(e_w_reg) * 34'(e_w_reg);
            f_tw_reg   <= 34'(e_tm_reg) * 34'(e_w_reg);

            g_seg_reg  <= f_seg_reg;
            g_tm_reg   <= f_tm_reg;
            g_q_reg    <= q_full[19:0];
            g_twq_reg  <= tw_sum[32:16];
            g_ww_reg   <= f_ww_reg[32:0];

            h_seg_reg  <= g_seg_reg;
            h_mq_reg   <= 37'(g_tm_reg) * 37'(g_q_reg);
            h_sw_reg   <= 61'(cfg.a15) * 61'(g_ww_reg);
            h_cw_reg   <= 53'(cfg.a2q15) * 53'(g_twq_reg);

            jet_reg    <= jet_next;
        end
    end

    assign jet = jet_reg;

endmodule

// ===== hdl/swj_tensor.sv =====
module swj_tensor import swj_pkg::*;
(
    input  logic      clk,
    input  logic      adv,
    input  axis_jet_t jx,
    input  axis_jet_t jy,
    output res_t      res
);

    function automatic logic [34:0] rnd16(input logic [50:0] raw);
        logic [51:0] sum;
        sum = {1'b0, raw} + 52'(HALF_Q16);
        return sum[50:16];
    endfunction

    function automatic logic [31:0] sat32(input logic [34:0] r, input logic neg);
        logic [31:0] res_v;
        if (neg)
        begin
            res_v = (r > 35'h0_8000_0000) ? 32'h8000_0000 : (~r[31:0]) + 32'd1;
        end
        else
        begin
            res_v = (r > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
        return res_v;
    endfunction

    // Stage J: magnitude products and the outside flag
    logic        j_zero_reg;
    logic [33:0] j_vv_reg;
    logic [40:0] j_sv_reg, j_vs_reg;
    logic [49:0] j_cv_reg, j_vc_reg;
    logic [47:0] j_ss_reg;
    logic        j_sv_neg_reg, j_vs_neg_reg, j_cv_neg_reg, j_ss_neg_reg, j_vc_neg_reg;

    // Stage K: round, saturate, zero outside
    logic [34:0] vv_r;
    res_t        res_next;
    res_t        res_reg;

    always_comb
    begin
        vv_r                = rnd16(51'(j_vv_reg));
        res_next.val_00     = j_zero_reg ? 17'd0 : vv_r[16:0];
        res_next.dx_10      = j_zero_reg ? 32'd0 : sat32(rnd16(51'(j_sv_reg)), j_sv_neg_reg);
        res_next.dy_01      = j_zero_reg ? 32'd0 : sat32(rnd16(51'(j_vs_reg)), j_vs_neg_reg);
        res_next.dxx_20     = j_zero_reg ? 32'd0 : sat32(rnd16(51'(j_cv_reg)), j_cv_neg_reg);
        res_next.dxy_11     = j_zero_reg ? 32'd0 : sat32(rnd16(51'(j_ss_reg)), j_ss_neg_reg);
        res_next.dyy_02     = j_zero_reg ? 32'd0 : sat32(rnd16(51'(j_vc_reg)), j_vc_neg_reg);
        res_next.inside_res = !j_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_zero_reg   <= (jx.v == 17'd0) || (jy.v == 17'd0);
            j_vv_reg     <= 34'(jx.v) * 34'(jy.v);
            j_sv_reg     <= 41'(jx.s_mag) * 41'(jy.v);
            j_vs_reg     <= 41'(jx.v) * 41'(jy.s_mag);
            j_cv_reg     <= 50'(jx.c_mag) * 50'(jy.v);
            j_ss_reg     <= 48'(jx.s_mag) * 48'(jy.s_mag);
            j_vc_reg     <= 50'(jx.v) * 50'(jy.c_mag);
            j_sv_neg_reg <= jx.s_neg;
            j_vs_neg_reg <= jy.s_neg;
            j_cv_neg_reg <= jx.c_neg;
            j_ss_neg_reg <= jx.s_neg ^ jy.s_neg;
            j_vc_neg_reg <= jy.c_neg;

            res_reg      <= res_next;
        end
    end

    assign res = res_reg;

endmodule
